@@ src/hsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Hash set package
// Shared sizes, codes and the home-slot hash of the linear-probe hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

  localparam int unsigned SLOTS     = 32;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned MAX_W     = 5;
  localparam int unsigned OUT_SLOT_W = 5;
  localparam int unsigned TOTAL_W   = 5;
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(16);

  localparam int unsigned HASH_MUL = 67;
  localparam int unsigned HASH_ADD = 32'h0012_3456;

  typedef enum logic [1:0] {
    ACT_CONTAINS = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK   = 3'd0,
    STAT_MISS = 3'd1,
    STAT_DUP  = 3'd2,
    STAT_FULL = 3'd3,
    STAT_BAD  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  // The home slot is the low bits of key * 67 + 0x123456; only the low key
  // bits reach the low bits of the product.
  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_BITS-1:0] k);
    logic [31:0] h;
    h = 32'(k[SLOT_W-1:0]) * HASH_MUL + HASH_ADD;
    return h[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/hsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Hash set controller
// Sequences accept, probe steps and commit, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_ctrl
  import hsl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!sts_i.done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ src/hsl_dp.sv @@
// ----------------------------------------------------------------------------
// Hash set datapath
// Key memory, slot tags, live count, probe pointer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_dp
  import hsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [63:0]          key_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [MAX_W-1:0]     cfg_wdata_i,
  output logic [2:0]                status_o,
  output logic [OUT_SLOT_W-1:0]     slot_index_o,
  output logic [TOTAL_W-1:0]        entry_total_o
);

  logic [KEY_BITS-1:0] key_mem [SLOTS];
  logic [KEY_BITS-1:0] rdata_q;
  tag_e                tag_q [SLOTS];

  action_e             act_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]   n_q;
  logic [SLOT_W-1:0]   free_q;
  logic                free_vld_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [MAX_W-1:0]    max_q;

  status_e             status_d, status_q;
  logic [SLOT_W-1:0]   slot_d, slot_q;
  logic [TOTAL_W-1:0]  total_q;

  tag_e                cur_tag;
  logic                key_bad;
  logic                hit;
  logic                free_ok;
  logic [SLOT_W-1:0]   free_pos;
  logic                wr_live;
  logic                wr_tomb;
  logic                wr_clear;

  assign cur_tag  = tag_q[pos_q];
  assign key_bad  = (key_q == '0) || (key_q == '1);
  assign hit      = (cur_tag == TAG_LIVE) && (rdata_q == key_q);
  assign free_ok  = free_vld_q || (cur_tag != TAG_LIVE);
  assign free_pos = free_vld_q ? free_q : pos_q;

  assign sts_o.done = (act_q == ACT_CLEAR) || key_bad || (cur_tag == TAG_EMPTY) || hit ||
                      (n_q == SLOT_W'(SLOTS - 1));

  always_comb begin
    status_d = STAT_OK;
    slot_d   = '0;
    count_d  = count_q;
    wr_live  = 1'b0;
    wr_tomb  = 1'b0;
    wr_clear = 1'b0;
    if (act_q == ACT_CLEAR) begin
      wr_clear = 1'b1;
      count_d  = '0;
    end else if (key_bad) begin
      status_d = STAT_BAD;
    end else begin
      case (act_q)
        ACT_CONTAINS: begin
          if (hit) begin
            slot_d = pos_q;
          end else begin
            status_d = STAT_MISS;
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            slot_d  = pos_q;
            wr_tomb = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
          end else begin
            status_d = STAT_MISS;
          end
        end
        default: begin
          if (hit) begin
            status_d = STAT_DUP;
            slot_d   = pos_q;
          end else if (count_q >= CNT_W'(max_q)) begin
            status_d = STAT_FULL;
          end else if (free_ok) begin
            slot_d  = free_pos;
            wr_live = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            status_d = STAT_FULL;
          end
        end
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.load) begin
      pos_d = home_slot(key_i[KEY_BITS-1:0]);
    end else if (cmd_i.step) begin
      pos_d = pos_q + SLOT_W'(1);
    end
  end

  // The read address follows the probe pointer, so rdata_q always holds the
  // key of the slot under pos_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_live) begin
      key_mem[free_pos] <= key_q;
    end
    rdata_q <= key_mem[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i] <= TAG_EMPTY;
      end
      count_q    <= '0;
      max_q      <= MAX_RESET;
      pos_q      <= '0;
      n_q        <= '0;
      free_vld_q <= 1'b0;
      act_q      <= ACT_CONTAINS;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        act_q      <= action_e'(action_i);
        n_q        <= '0;
        free_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        n_q <= n_q + SLOT_W'(1);
        if ((cur_tag == TAG_TOMB) && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        if (wr_clear) begin
          for (int i = 0; i < SLOTS; i++) begin
            tag_q[i] <= TAG_EMPTY;
          end
        end else if (wr_live) begin
          tag_q[free_pos] <= TAG_LIVE;
        end else if (wr_tomb) begin
          tag_q[pos_q] <= TAG_TOMB;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i[KEY_BITS-1:0];
    end
    if (cmd_i.step && (cur_tag == TAG_TOMB) && !free_vld_q) begin
      free_q <= pos_q;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      total_q  <= count_d[TOTAL_W-1:0];
    end
  end

  assign status_o      = status_q;
  assign slot_index_o  = OUT_SLOT_W'(slot_q);
  assign entry_total_o = total_q;

endmodule

`default_nettype wire

@@ src/hash_set_linear_probe.sv @@
// ----------------------------------------------------------------------------
// Hash set with linear probing
// A 32-slot set of 64-bit keys with tombstones, a live count and a limit.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_stall_o, action_i, key_i   into the block
//   output    out_valid_o, out_stall_i, status_o,       out of the block
//             slot_index_o, entry_total_o
//   config    cfg_we_i, cfg_wdata_i                     into the block
//
// An item is accepted, then its probe visits 1 to 32 slots from its home slot.
// One key memory entry is read per cycle, setting the rate if not stalled.
// A new item is accepted while the previous result waits in the output
// register; a stalled output holds a finished item at its commit step.
// Reset empties all tags at once; key memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_linear_probe
  import hsl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] key_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [4:0]       slot_index_o,
  output logic [4:0]       entry_total_o,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  hsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hsl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .key_i         (key_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .entry_total_o (entry_total_o)
  );

endmodule

`default_nettype wire

@@ src/hsl_assert.sv @@
// ----------------------------------------------------------------------------
// Hash set port checks
// Concurrent checks on the top-level ports, bound to the hash set.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_assert
  import hsl_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [4:0]  slot_index_o,
  input wire logic [4:0]  entry_total_o
);

  // The block works on one item at a time, so it is busy after a beat.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is still in work");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STAT_BAD))
    else $error("status code out of range");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_MISS || status_o == STAT_FULL ||
                     status_o == STAT_BAD)) |-> (slot_index_o == '0))
    else $error("slot index nonzero on a failed operation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(slot_index_o) &&
       $stable(entry_total_o)))
    else $error("stalled output beat changed");

endmodule

bind hash_set_linear_probe hsl_assert u_hsl_assert (.*);

`default_nettype wire

@@ sim/hash_set_linear_probe_tb.sv @@
// ----------------------------------------------------------------------------
// Hash set with linear probing testbench
// Drives contains, add, remove and clear beats into the set, predicts every
// reply from a model of the slot table kept here, and compares each reply
// field by field. Directed tests cover reserved keys, limits and probe chains
// with tombstones; random phases run under several limits with random gaps,
// output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_linear_probe_tb
  import hsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned POOL_DEPTH  = 64;
  localparam logic [63:0] KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_e    status;
    logic [4:0] slot;
    logic [4:0] total;
  } set_reply_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i    = 2'd0;
  logic [63:0] key_i       = 64'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [4:0]  slot_index_o;
  logic [4:0]  entry_total_o;
  logic        cfg_we_i    = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;

  logic [63:0] table_key [SLOTS];
  tag_e        table_tag [SLOTS];
  int unsigned live_count;
  int unsigned entry_limit;

  set_reply_t  pending_replies[$];
  logic [63:0] key_pool [POOL_DEPTH];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  int unsigned hold_req;
  bit          in_idle;
  bit          out_idle;

  hash_set_linear_probe dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .entry_total_o(entry_total_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [4:0] probe_start(input logic [63:0] key);
    logic [63:0] h;
    h = key * 64'(HASH_MUL) + 64'(HASH_ADD);
    return h[4:0];
  endfunction

  function automatic bit locate_key(input logic [63:0] key, output logic [4:0] at);
    int unsigned p;
    p = 32'(probe_start(key));
    at = '0;
    for (int unsigned n = 0; n < SLOTS; n++) begin
      if (table_tag[p] == TAG_EMPTY) return 1'b0;
      if (table_tag[p] == TAG_LIVE && table_key[p] == key) begin
        at = p[4:0];
        return 1'b1;
      end
      p = (p + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  task automatic predict_reply(input action_e act, input logic [63:0] key);
    set_reply_t  r;
    logic [4:0]  at;
    bit          hit;
    int unsigned p;
    r.status = STAT_OK;
    r.slot   = '0;
    if (act == ACT_CLEAR) begin
      foreach (table_tag[i]) table_tag[i] = TAG_EMPTY;
      live_count = 0;
    end else if (key == 64'd0 || key == KEY_ONES) begin
      r.status = STAT_BAD;
    end else begin
      hit = locate_key(key, at);
      case (act)
        ACT_CONTAINS: begin
          if (hit) r.slot = at;
          else r.status = STAT_MISS;
        end
        ACT_REMOVE: begin
          if (hit) begin
            table_tag[at] = TAG_TOMB;
            if (live_count > 0) live_count--;
            r.slot = at;
          end else begin
            r.status = STAT_MISS;
          end
        end
        default: begin
          if (hit) begin
            r.status = STAT_DUP;
            r.slot   = at;
          end else if (live_count >= entry_limit) begin
            r.status = STAT_FULL;
          end else begin
            r.status = STAT_FULL;
            p = 32'(probe_start(key));
            for (int unsigned n = 0; n < SLOTS; n++) begin
              if (table_tag[p] != TAG_LIVE) begin
                table_tag[p] = TAG_LIVE;
                table_key[p] = key;
                live_count++;
                r.slot   = p[4:0];
                r.status = STAT_OK;
                break;
              end
              p = (p + 1) % SLOTS;
            end
          end
        end
      endcase
    end
    r.total = live_count[4:0];
    pending_replies.push_back(r);
  endtask

  function automatic int unsigned pick_run();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 1;
    if (r < 92) return $urandom_range(4, 2);
    if (r < 98) return $urandom_range(12, 5);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(1) ? 64'd0 : KEY_ONES;
    if (r < 40) return key_pool[$urandom_range(POOL_DEPTH - 1)];
    if (r < 65) return ({$urandom, $urandom} & ~64'h1F) | 64'($urandom_range(5, 2));
    if (r < 80) return 64'($urandom_range(300, 1));
    return {$urandom, $urandom};
  endfunction

  function automatic action_e pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 1) return ACT_CLEAR;
    if (r < 43) return ACT_ADD;
    if (r < 70) return ACT_CONTAINS;
    return ACT_REMOVE;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_op(input action_e act, input logic [63:0] key);
    int unsigned gap;
    gap = (in_idle && $urandom_range(99) >= 55) ? pick_run() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    do @(posedge clk_i); while (in_stall_o);
    predict_reply(act, key);
    if (act == ACT_ADD && key != 64'd0 && key != KEY_ONES)
      key_pool[$urandom_range(POOL_DEPTH - 1)] = key;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_limit(input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[4:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    entry_limit = value;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned lim,
                           input bit idle_in, input bit idle_out);
    wait_drain();
    set_limit(lim);
    in_idle  = idle_in;
    out_idle = idle_out;
    repeat (count) send_op(pick_action(), pick_key());
  endtask

  task automatic test_basic_ops();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_op(ACT_CONTAINS, 64'd5);
    send_op(ACT_ADD, 64'd5);
    send_op(ACT_ADD, 64'd5);
    send_op(ACT_CONTAINS, 64'd5);
    send_op(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFE);
    send_op(ACT_ADD, 64'd1);
    send_op(ACT_CONTAINS, 64'd0);
    send_op(ACT_ADD, KEY_ONES);
    send_op(ACT_REMOVE, 64'd0);
    send_op(ACT_REMOVE, 64'd5);
    send_op(ACT_REMOVE, 64'd5);
    send_op(ACT_CLEAR, KEY_ONES);
    send_op(ACT_CONTAINS, 64'd1);
  endtask

  task automatic test_limit();
    wait_drain();
    set_limit(1);
    send_op(ACT_ADD, 64'd7);
    send_op(ACT_ADD, 64'd9);
    send_op(ACT_ADD, 64'd7);
    send_op(ACT_REMOVE, 64'd7);
    send_op(ACT_ADD, 64'd9);
    send_op(ACT_CLEAR, 64'd0);
  endtask

  task automatic test_probe_chain();
    wait_drain();
    set_limit(31);
    send_op(ACT_ADD, 64'd3);
    send_op(ACT_ADD, 64'd35);
    send_op(ACT_ADD, 64'd67);
    send_op(ACT_REMOVE, 64'd35);
    send_op(ACT_CONTAINS, 64'd67);
    send_op(ACT_ADD, 64'd99);
    send_op(ACT_ADD, 64'd35);
    send_op(ACT_CLEAR, 64'd12345);
  endtask

  task automatic test_backpressure();
    wait_drain();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    hold_req = 300;
    repeat (12) send_op(pick_action(), pick_key());
    wait_drain();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    repeat (20) send_op(pick_action(), pick_key());
    wait_drain();
  endtask

  task automatic test_random_mix();
    foreach (key_pool[i]) key_pool[i] = 64'($urandom_range(200, 1));
    run_phase(500, 31, 1'b1, 1'b1);
    run_phase(300, 8, 1'b0, 1'b0);
    run_phase(120, 1, 1'b1, 1'b0);
    run_phase(450, 31, 1'b0, 1'b1);
    run_phase(250, 24, 1'b1, 1'b1);
    run_phase(200, $urandom_range(31, 1), 1'b1, 1'b1);
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if (hold_req != 0) begin
      out_stall_i <= 1'b1;
      stall_left = hold_req - 1;
      hold_req   = 0;
    end else if (out_idle && $urandom_range(99) < 20) begin
      out_stall_i <= 1'b1;
      stall_left = pick_run() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    set_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("reply beat with nothing pending, status", status_o, 0);
      end else begin
        want = pending_replies.pop_front();
        if (status_o != want.status) flag_mismatch("status", status_o, want.status);
        if (slot_index_o != want.slot) flag_mismatch("slot_index", slot_index_o, want.slot);
        if (entry_total_o != want.total)
          flag_mismatch("entry_total", entry_total_o, want.total);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (table_tag[i]) table_tag[i] = TAG_EMPTY;
    foreach (table_key[i]) table_key[i] = '0;
    live_count  = 0;
    entry_limit = 32'(MAX_RESET);
    mismatches  = 0;
    quiet_cycles = 0;
    stall_left  = 0;
    hold_req    = 0;
    in_idle     = 1'b0;
    out_idle    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_limit();
    test_probe_chain();
    test_backpressure();
    test_random_mix();

    wait_drain();
    repeat (40) @(posedge clk_i);
    if (pending_replies.size() != 0)
      flag_mismatch("replies left over", 0, pending_replies.size());
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/hsl_pkg.sv
src/hsl_ctrl.sv
src/hsl_dp.sv
src/hash_set_linear_probe.sv
src/hsl_assert.sv
sim/hash_set_linear_probe_tb.sv
